@@ hdl/b64d_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, constants and the character classifier of the base64 decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam int CharW    = 8;
  localparam int CountW   = 16;
  localparam int SymW     = 6;
  localparam int FifoDepthDefault = 4;

  localparam logic [CountW-1:0] CAP_RESET  = 16'hFFFF;
  localparam logic [CountW-1:0] COUNT_MAX  = 16'hFFFF;

  localparam logic [CharW-1:0] CH_NUL   = 8'h00;
  localparam logic [CharW-1:0] CH_UP_A  = 8'h41;
  localparam logic [CharW-1:0] CH_UP_Z  = 8'h5A;
  localparam logic [CharW-1:0] CH_LO_A  = 8'h61;
  localparam logic [CharW-1:0] CH_LO_Z  = 8'h7A;
  localparam logic [CharW-1:0] CH_DIG_0 = 8'h30;
  localparam logic [CharW-1:0] CH_DIG_9 = 8'h39;
  localparam logic [CharW-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CharW-1:0] CH_SLASH = 8'h2F;
  localparam logic [CharW-1:0] CH_PAD   = 8'h3D;

  localparam logic [CharW-1:0] LOWER_OFS = 8'd26;
  localparam logic [CharW-1:0] DIGIT_OFS = 8'd52;
  localparam logic [SymW-1:0]  SYM_PLUS  = 6'd62;
  localparam logic [SymW-1:0]  SYM_SLASH = 6'd63;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_DONE = 2'd1,
    KIND_OVF  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         data;
    logic [CountW-1:0]  count;
    logic               last;
  } res_t;

  typedef struct packed {
    logic [1:0] num;
    res_t       res0;
    res_t       res1;
  } push_t;

  typedef struct packed {
    logic            is_sym;
    logic            is_term;
    logic [SymW-1:0] val;
  } sym_t;

  function automatic sym_t classify(input logic [CharW-1:0] c);
    sym_t             s;
    logic [CharW-1:0] t;
    s = '0;
    t = '0;
    if (c >= CH_UP_A && c <= CH_UP_Z) begin
      t = c - CH_UP_A;
      s.is_sym = 1'b1;
      s.val = t[SymW-1:0];
    end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
      t = c - CH_LO_A + LOWER_OFS;
      s.is_sym = 1'b1;
      s.val = t[SymW-1:0];
    end else if (c >= CH_DIG_0 && c <= CH_DIG_9) begin
      t = c - CH_DIG_0 + DIGIT_OFS;
      s.is_sym = 1'b1;
      s.val = t[SymW-1:0];
    end else if (c == CH_PLUS) begin
      s.is_sym = 1'b1;
      s.val = SYM_PLUS;
    end else if (c == CH_SLASH) begin
      s.is_sym = 1'b1;
      s.val = SYM_SLASH;
    end else if (c == CH_PAD || c == CH_NUL) begin
      s.is_term = 1'b1;
    end
    return s;
  endfunction

endpackage

@@ hdl/b64d_decode.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_decode
// Decoder state, capacity register and per-item result generation.
// ----------------------------------------------------------------------------
module b64d_decode (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [b64d_pkg::CountW-1:0] cfg_wdata,
  input  logic                        in_acc,
  input  logic [b64d_pkg::CharW-1:0]  in_char,
  output b64d_pkg::push_t             push
);
  import b64d_pkg::*;

  logic [CountW-1:0] cap_r;
  logic [1:0]        gp_r, gp_nxt;
  logic [7:0]        pb_r, pb_nxt;
  logic [CountW-1:0] bd_r, bd_nxt;
  logic              drain_r, drain_nxt;

  sym_t              sym;
  logic [CountW-1:0] bd_inc;
  logic [7:0]        byte_val;
  logic              is_nul;
  push_t             p;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= CAP_RESET;
      gp_r    <= '0;
      pb_r    <= '0;
      bd_r    <= '0;
      drain_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (in_acc) begin
        gp_r    <= gp_nxt;
        pb_r    <= pb_nxt;
        bd_r    <= bd_nxt;
        drain_r <= drain_nxt;
      end
    end
  end

  always_comb begin
    sym      = classify(in_char);
    is_nul   = (in_char == CH_NUL);
    bd_inc   = (bd_r == COUNT_MAX) ? bd_r : bd_r + 1'b1;
    gp_nxt   = gp_r;
    pb_nxt   = pb_r;
    bd_nxt   = bd_r;
    drain_nxt = drain_r;
    p        = '0;
    p.res0.kind = KIND_DATA;
    p.res1.kind = KIND_DATA;
    byte_val = '0;

    unique case (gp_r)
      2'd1:    byte_val = pb_r | {6'd0, sym.val[5:4]};
      2'd2:    byte_val = pb_r | {4'd0, sym.val[5:2]};
      2'd3:    byte_val = pb_r | {2'd0, sym.val};
      default: byte_val = '0;
    endcase

    priority if (drain_r) begin
      if (is_nul) begin
        gp_nxt = '0; pb_nxt = '0; bd_nxt = '0; drain_nxt = 1'b0;
      end
    end else if ((gp_r == 2'd0 && bd_r >= cap_r) ||
                 (sym.is_term && (gp_r == 2'd0 || is_nul))) begin
      // finish the string
      p.num = 2'd1;
      p.res0.kind = KIND_DONE;
      p.res0.count = bd_r;
      p.res0.last = 1'b1;
      if (is_nul) begin
        gp_nxt = '0; pb_nxt = '0; bd_nxt = '0; drain_nxt = 1'b0;
      end else begin
        drain_nxt = 1'b1;
      end
    end else if (sym.is_term) begin
      gp_nxt = '0;
      pb_nxt = '0;
    end else if (sym.is_sym) begin
      if (gp_r == 2'd0) begin
        pb_nxt = {sym.val, 2'b00};
        gp_nxt = 2'd1;
      end else begin
        p.res0.kind = KIND_DATA;
        p.res0.data = byte_val;
        bd_nxt = bd_inc;
        unique case (gp_r)
          2'd1:    pb_nxt = {sym.val[3:0], 4'd0};
          2'd2:    pb_nxt = {sym.val[1:0], 6'd0};
          default: pb_nxt = '0;
        endcase
        if (gp_r == 2'd3) begin
          gp_nxt = 2'd0;
          if (bd_inc >= cap_r) begin
            p.num = 2'd2;
            p.res1.kind = KIND_DONE;
            p.res1.count = bd_inc;
            p.res1.last = 1'b1;
            drain_nxt = 1'b1;
          end else begin
            p.num = 2'd1;
            p.res0.last = 1'b1;
          end
        end else if (bd_inc >= cap_r) begin
          p.num = 2'd2;
          p.res1.kind = KIND_OVF;
          p.res1.last = 1'b1;
          drain_nxt = 1'b1;
        end else begin
          p.num = 2'd1;
          p.res0.last = 1'b1;
          gp_nxt = gp_r + 2'd1;
        end
      end
    end else begin
      // skipped character, state unchanged
      p.num = 2'd0;
    end

    if (!in_acc) begin
      p.num = 2'd0;
    end
  end

  assign push = p;

endmodule

@@ hdl/b64d_out_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_out_fifo
// Result queue: takes up to two results per cycle, hands out one.
// ----------------------------------------------------------------------------
module b64d_out_fifo #(
  parameter int Depth = b64d_pkg::FifoDepthDefault
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  b64d_pkg::push_t              push,
  input  logic                         pop,
  output b64d_pkg::res_t               head,
  output logic                         not_empty,
  output logic                         room2,
  output logic [$clog2(Depth+1)-1:0]   level
);
  import b64d_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntRoom = CntW'(Depth - 2);

  res_t            mem [Depth];
  logic [PtrW-1:0] wp_r, wp_nxt, rp_r, rp_nxt, wp1;
  logic [CntW-1:0] cnt_r, cnt_nxt;

  function automatic logic [PtrW-1:0] inc_ptr(input logic [PtrW-1:0] p);
    return (p == PtrLast) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wp1 = inc_ptr(wp_r);
    unique case (push.num)
      2'd1:    wp_nxt = wp1;
      2'd2:    wp_nxt = inc_ptr(wp1);
      default: wp_nxt = wp_r;
    endcase
    rp_nxt  = pop ? inc_ptr(rp_r) : rp_r;
    cnt_nxt = cnt_r + CntW'(push.num) - CntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      mem[wp_r] <= push.res0;
    end
    if (push.num == 2'd2) begin
      mem[wp1] <= push.res1;
    end
  end

  assign head      = mem[rp_r];
  assign not_empty = (cnt_r != '0);
  assign room2     = (cnt_r <= CntRoom);
  assign level     = cnt_r;

endmodule

@@ hdl/base64_stream_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Streaming base64 decoder, one character per item, bytes out as they form.
// A result is written into the result queue when its character is accepted
// and offered from there. Throughput: one character per cycle while the queue
// has room; a character that yields two results is absorbed by the result queue of Depth entries.
// Input is taken while the queue has room for two results.
// Reset: synchronous active-low; clears decoder state and queue, capacity 65535.
// ----------------------------------------------------------------------------
module base64_stream_decoder #(
  parameter int Depth = b64d_pkg::FifoDepthDefault
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [b64d_pkg::CountW-1:0] cfg_wdata,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // [7:0] char_code
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [23:0]                 out_tdata,  // [7:0] data_byte, [23:8] byte_count
  output logic [1:0]                  out_tuser,  // [1:0] kind
  output logic                        out_tlast
);
  import b64d_pkg::*;

  push_t                       push;
  res_t                        head;
  logic                        in_acc;
  logic                        pop;
  logic                        room2;
  logic [$clog2(Depth+1)-1:0]  level;

  assign in_acc = in_tvalid && in_tready;
  assign pop    = out_tvalid && out_tready;

  b64d_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_acc    (in_acc),
    .in_char   (in_tdata),
    .push      (push)
  );

  b64d_out_fifo #(
    .Depth (Depth)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (pop),
    .head      (head),
    .not_empty (out_tvalid),
    .room2     (room2),
    .level     (level)
  );

  assign in_tready = room2;
  assign out_tdata = {head.count, head.data};
  assign out_tuser = head.kind;
  assign out_tlast = head.last;

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level <= ($clog2(Depth+1))'(Depth))
    else $error("result queue overfilled");

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_DONE || out_tuser == KIND_OVF) |-> out_tlast)
    else $error("done or overflow result without last");

  a_ovf_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_OVF |-> out_tdata == '0)
    else $error("overflow result carries data");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("results offered after reset");

endmodule

@@ tb/b64_decode_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64_decode_checker
// Watches the character and result channels of the base64 stream decoder,
// tracks the decoder state and capacity on its own, works out the results of
// every accepted character and compares each accepted result field by field.
// ----------------------------------------------------------------------------
module b64_decode_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [b64d_pkg::CountW-1:0] cfg_wdata,
  input  logic                        in_tvalid,
  input  logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // [7:0] char_code
  input  logic                        out_tvalid,
  input  logic                        out_tready,
  input  logic [23:0]                 out_tdata,  // [7:0] data_byte, [23:8] byte_count
  input  logic [1:0]                  out_tuser,  // [1:0] kind
  input  logic                        out_tlast,
  output int                          mismatches,
  output int                          pending,
  output int                          checked
);
  import b64d_pkg::*;

  localparam logic [6:0] SymTerm = 7'd64;
  localparam logic [6:0] SymSkip = 7'd65;

  logic [CountW-1:0] capacity;
  logic [1:0]        grp_pos;
  logic [7:0]        part_byte;
  logic [CountW-1:0] bytes_out;
  logic              draining;
  res_t              expected_results[$];
  res_t              new_res[2];
  int                num_new;

  function automatic logic [6:0] symbol_of(input logic [7:0] c);
    if (c >= CH_UP_A && c <= CH_UP_Z) return 7'(c - CH_UP_A);
    if (c >= CH_LO_A && c <= CH_LO_Z) return 7'(c - CH_LO_A + LOWER_OFS);
    if (c >= CH_DIG_0 && c <= CH_DIG_9) return 7'(c - CH_DIG_0 + DIGIT_OFS);
    if (c == CH_PLUS) return 7'(SYM_PLUS);
    if (c == CH_SLASH) return 7'(SYM_SLASH);
    if (c == CH_PAD || c == CH_NUL) return SymTerm;
    return SymSkip;
  endfunction

  task automatic clear_string();
    grp_pos   = 2'd0;
    part_byte = 8'h00;
    bytes_out = '0;
    draining  = 1'b0;
  endtask

  task automatic add_result(input kind_t k, input logic [7:0] d,
                            input logic [CountW-1:0] n);
    new_res[num_new].kind  = k;
    new_res[num_new].data  = d;
    new_res[num_new].count = n;
    new_res[num_new].last  = 1'b0;
    num_new++;
  endtask

  // NUL readies the next string, anything else drains up to NUL
  task automatic end_string(input logic [7:0] c);
    if (c == CH_NUL) begin
      clear_string();
    end else begin
      draining = 1'b1;
    end
  endtask

  task automatic predict_char(input logic [7:0] c);
    logic [6:0] s;
    logic [5:0] v;
    logic [7:0] b;
    num_new = 0;
    s = symbol_of(c);
    v = s[5:0];
    b = 8'h00;
    if (draining) begin
      if (c == CH_NUL) clear_string();
    end else if (grp_pos == 2'd0 && bytes_out >= capacity) begin
      add_result(KIND_DONE, 8'h00, bytes_out);
      end_string(c);
    end else if (s == SymTerm) begin
      if (grp_pos == 2'd0 || c == CH_NUL) begin
        add_result(KIND_DONE, 8'h00, bytes_out);
        end_string(c);
      end else begin
        grp_pos   = 2'd0;
        part_byte = 8'h00;
      end
    end else if (s != SymSkip) begin
      if (grp_pos == 2'd0) begin
        part_byte = {v, 2'b00};
        grp_pos   = 2'd1;
      end else begin
        case (grp_pos)
          2'd1: begin
            b = part_byte | {6'd0, v[5:4]};
            part_byte = {v[3:0], 4'd0};
          end
          2'd2: begin
            b = part_byte | {4'd0, v[5:2]};
            part_byte = {v[1:0], 6'd0};
          end
          default: begin
            b = part_byte | {2'd0, v};
            part_byte = 8'h00;
          end
        endcase
        add_result(KIND_DATA, b, '0);
        if (bytes_out != COUNT_MAX) bytes_out++;
        if (grp_pos == 2'd3) begin
          grp_pos = 2'd0;
          if (bytes_out >= capacity) begin
            add_result(KIND_DONE, 8'h00, bytes_out);
            end_string(c);
          end
        end else if (bytes_out >= capacity) begin
          add_result(KIND_OVF, 8'h00, '0);
          draining = 1'b1;
        end else begin
          grp_pos++;
        end
      end
    end
    if (num_new > 0) new_res[num_new-1].last = 1'b1;
    for (int i = 0; i < num_new; i++) expected_results.push_back(new_res[i]);
  endtask

  function automatic void check_field(input string name, input logic [15:0] exp_v,
                                      input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  task automatic check_result();
    res_t e;
    if (expected_results.size() == 0) begin
      $error("result with nothing expected: kind %0d data 0x%0h count %0d last %0b",
             out_tuser, out_tdata[7:0], out_tdata[23:8], out_tlast);
      mismatches++;
    end else begin
      e = expected_results.pop_front();
      check_field("kind", 16'(e.kind), 16'(out_tuser));
      check_field("data_byte", 16'(e.data), 16'(out_tdata[7:0]));
      check_field("byte_count", e.count, out_tdata[23:8]);
      check_field("last", 16'(e.last), 16'(out_tlast));
      checked++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      capacity = CAP_RESET;
      clear_string();
      expected_results.delete();
    end else begin
      if (out_tvalid && out_tready) check_result();
      if (in_tvalid && in_tready) predict_char(in_tdata);
      if (cfg_we) capacity = cfg_wdata;
    end
    pending = expected_results.size();
  end

endmodule

@@ tb/tb_base64_stream_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_base64_stream_decoder
// Drives the base64 stream decoder with directed strings for the capacity,
// padding and terminator cases, then random strings over several capacity
// settings, with random gaps and back-pressure; a checker module judges
// every result and this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_base64_stream_decoder;
  import b64d_pkg::*;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CountW-1:0]   cfg_wdata = '0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [7:0]          in_tdata = 8'h00;   // [7:0] char_code
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [23:0]         out_tdata;          // [7:0] data_byte, [23:8] byte_count
  logic [1:0]          out_tuser;          // [1:0] kind
  logic                out_tlast;

  int mismatches;
  int pending;
  int checked;
  int chars_sent = 0;
  int cap_writes = 0;
  int in_idle_pct = 7;
  int out_stall_pct = 7;

  base64_stream_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  b64_decode_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= out_stall_pct);
  end

  function automatic logic [7:0] sym_char(input logic [5:0] v);
    if (v < LOWER_OFS) return CH_UP_A + 8'(v);
    if (v < DIGIT_OFS) return CH_LO_A + 8'(v - LOWER_OFS);
    if (v < SYM_PLUS) return CH_DIG_0 + 8'(v - DIGIT_OFS);
    if (v == SYM_PLUS) return CH_PLUS;
    return CH_SLASH;
  endfunction

  task automatic send_char(input logic [7:0] c);
    if (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(8'(s[i]));
  endtask

  // hold the sender until every expected result is out and the block is quiet
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cap(input logic [CountW-1:0] v);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    cap_writes++;
  endtask

  // mostly well-formed text with some noise, stray padding and missing NUL
  task automatic send_string();
    int n;
    int r;
    n = $urandom_range(0, 14);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 5) begin
        send_char(8'($urandom_range(1, 255)));
      end else if (r < 7) begin
        send_char(CH_PAD);
      end else begin
        send_char(sym_char(6'($urandom_range(0, 63))));
      end
    end
    if ($urandom_range(0, 1) == 1) repeat ($urandom_range(1, 2)) send_char(CH_PAD);
    if ($urandom_range(0, 9) != 0) send_char(CH_NUL);
  endtask

  initial begin
    logic [CountW-1:0] cap_plan [8];
    int target;
    cap_plan = '{CAP_RESET, 16'd1, 16'd2, 16'd3, 16'd0, 16'd5, 16'd0, 16'd0};
    cap_plan[6] = 16'($urandom_range(0, 16));
    cap_plan[7] = 16'($urandom_range(0, 65535));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // full groups, padding inside and at the start of a group, drain to NUL
    send_text("TW/+az09Q==");
    send_char(8'hFF);
    send_char(CH_NUL);
    // capacity already met: NUL clears, any other character drains
    write_cap(16'd0);
    send_char(CH_NUL);
    send_text("~");
    send_char(CH_NUL);
    // overflow on the third symbol
    write_cap(16'd2);
    send_text("AAAA");
    send_char(CH_NUL);
    // capacity hit on the fourth symbol, then NUL inside a group
    write_cap(16'd3);
    send_text("////");
    send_char(CH_NUL);
    send_text("AB");
    send_char(CH_NUL);

    for (int p = 0; p < 8; p++) begin
      write_cap(cap_plan[p]);
      in_idle_pct   = (p == 5) ? 0 : 7;
      out_stall_pct = (p == 5) ? 0 : 7;
      target = chars_sent + 80;
      while (chars_sent < target) begin
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 4)) send_char(8'($urandom_range(0, 255)));
        end else begin
          send_string();
        end
      end
    end

    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
    @(negedge clk);

    $display("summary: %0d characters sent, %0d results checked, %0d capacity writes",
             chars_sent, checked, cap_writes);
    if (mismatches == 0 && pending == 0) begin
      $display("tb_base64_stream_decoder: done, clean");
    end else begin
      $display("tb_base64_stream_decoder: done, errors");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("tb_base64_stream_decoder: done, errors");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/b64d_pkg.sv
hdl/b64d_decode.sv
hdl/b64d_out_fifo.sv
hdl/base64_stream_decoder.sv
tb/b64_decode_checker.sv
tb/tb_base64_stream_decoder.sv
